// ===== sv/ppd_pkg.sv =====
// Shared types and constants for the pose PD controller core.
// No dependencies; imported by every module of the block.
package ppd_pkg;

    localparam int YAW_W       = 19;
    localparam int CFG_DW      = 32;
    localparam int CFG_AW      = 4;
    localparam int THRUST_W    = 7;
    localparam int PIPE_STAGES = 5;

    localparam logic [THRUST_W-1:0] THRUST_RST     = 7'd100;
    localparam logic [THRUST_W-1:0] THRUST_INT_MIN = 7'd20;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_HOLD   = 2'd1,
        REG_THRUST = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                enable;
        logic                hold_mode;
        logic [THRUST_W-1:0] max_thrust_pct;
    } cfg_t;

    // One load strobe per pipeline register bank
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
        logic ld_s4;
        logic ld_s5;
        logic ld_out;
    } pipe_ld_t;

endpackage

// ===== sv/ppd_cfg.sv =====
// APB-style configuration registers: enable, hold mode, max thrust percent.
// Depends on ppd_pkg.
module ppd_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppd_pkg::CFG_AW-1:0]  paddr,
    input  logic [ppd_pkg::CFG_DW-1:0]  pwdata,
    output logic [ppd_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output ppd_pkg::cfg_t               cfg
);
    import ppd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE: cfg_next.enable         = pwdata[0];
                REG_HOLD:   cfg_next.hold_mode      = pwdata[0];
                REG_THRUST: cfg_next.max_thrust_pct = pwdata[THRUST_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLE: prdata = CFG_DW'(cfg_reg.enable);
            REG_HOLD:   prdata = CFG_DW'(cfg_reg.hold_mode);
            REG_THRUST: prdata = CFG_DW'(cfg_reg.max_thrust_pct);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.hold_mode      <= 1'b1;
            cfg_reg.max_thrust_pct <= THRUST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/ppd_mulk.sv =====
// Signed value times a constant gain, rounded to nearest (ties away from zero).
// Depends on ppd_pkg.
module ppd_mulk #(
    parameter int               AW = 32,
    parameter int               FB = 16,
    parameter logic [FB+2:0]    KV = '0
) (
    input  logic signed [AW-1:0] a,
    output logic signed [AW+3:0] p
);
    import ppd_pkg::*;

    localparam int KW = FB + 3;
    localparam int PW = AW + KW + 1;
    localparam int RW = AW + 4;

    logic [AW-1:0] mag;
    logic [PW-1:0] prod;
    logic [RW-1:0] rmag;

    // Round the magnitude, then restore the sign
    assign mag  = a[AW-1] ? AW'(-a) : AW'(a);
    assign prod = PW'(mag) * PW'(KV) + (PW'(1) << (FB - 1));
    assign rmag = RW'(prod >> FB);
    assign p    = a[AW-1] ? -$signed(rmag) : $signed(rmag);

endmodule

// ===== sv/ppd_div10.sv =====
// Pipelined signed divide by ten, truncating toward zero, shift-add form.
// Depends on ppd_pkg; stages advance on the stage load strobes.
module ppd_div10 #(
    parameter int DW = 32
) (
    input  logic                 clk,
    input  ppd_pkg::pipe_ld_t    ld,
    input  logic signed [DW-1:0] dividend,
    output logic signed [DW-1:0] quotient
);
    import ppd_pkg::*;

    localparam logic [DW-1:0] RMAX = DW'(9);

    logic [DW-1:0] m2_reg, m3_reg, m4_reg;
    logic          neg2_reg, neg3_reg, neg4_reg;
    logic [DW-1:0] qa3_reg, q4_reg;
    logic signed [DW-1:0] q5_reg;

    logic [DW-1:0] m2_next;
    logic [DW-1:0] t3, qa3_next;
    logic [DW-1:0] u4, v4, w4, q4_next;
    logic [DW-1:0] r5, qd5;
    logic signed [DW-1:0] q5_next;

    assign m2_next  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);

    assign t3       = (m2_reg >> 1) + (m2_reg >> 2);
    assign qa3_next = t3 + (t3 >> 4);

    assign u4       = qa3_reg + (qa3_reg >> 8);
    assign v4       = u4 + (u4 >> 16);
    assign w4       = v4 + (v4 >> 32);
    assign q4_next  = w4 >> 3;

    // Estimate is low by at most one; fix up from the remainder
    assign r5       = m4_reg - ((q4_reg << 3) + (q4_reg << 1));
    assign qd5      = q4_reg + DW'(r5 > RMAX);
    assign q5_next  = neg4_reg ? -$signed(qd5) : $signed(qd5);

    assign quotient = q5_reg;

    always_ff @(posedge clk)
    begin
        if (ld.ld_s2)
        begin
            m2_reg   <= m2_next;
            neg2_reg <= dividend[DW-1];
        end
        if (ld.ld_s3)
        begin
            m3_reg   <= m2_reg;
            neg3_reg <= neg2_reg;
            qa3_reg  <= qa3_next;
        end
        if (ld.ld_s4)
        begin
            m4_reg   <= m3_reg;
            neg4_reg <= neg3_reg;
            q4_reg   <= q4_next;
        end
        if (ld.ld_s5)
        begin
            q5_reg <= q5_next;
        end
    end

endmodule

// ===== sv/ppd_datapath.sv =====
// Error forming, PD terms, z integral and result registers of the controller.
// Depends on ppd_pkg, ppd_mulk and ppd_div10.
module ppd_datapath #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppd_pkg::pipe_ld_t                   ld,
    input  ppd_pkg::cfg_t                       cfg,
    input  logic signed [DW-1:0]                meas_x,
    input  logic signed [DW-1:0]                meas_z,
    input  logic signed [ppd_pkg::YAW_W-1:0]    meas_yaw,
    output logic signed [DW-1:0]                force_x,
    output logic signed [DW-1:0]                force_z,
    output logic signed [DW-1:0]                torque_yaw
);
    import ppd_pkg::*;

    localparam int     KW      = FB + 3;
    localparam int     CW      = FB + 2;
    localparam longint ONE_Q   = 64'sd1 <<< FB;
    localparam longint KP_L    = (8 * ONE_Q + 5) / 10;
    localparam longint KD_L    = (3 * ONE_Q + 5) / 10;
    localparam longint KDY_L   = (4 * ONE_Q + 5) / 10;
    localparam longint KI_L    = (38 * ONE_Q + 500) / 1000;
    localparam longint LFZ_L   = (24 * ONE_Q + 5) / 10;
    localparam longint LFX_L   = (12 * ONE_Q + 5) / 10;
    localparam longint LINT_L  = (6000 * ONE_Q + 70) / 141;
    localparam longint PIH_L   = (64'sd3298672286 * ONE_Q + 64'sd500000000) / 64'sd1000000000;
    localparam longint TPI_L   = (64'sd6283185307 * ONE_Q + 64'sd500000000) / 64'sd1000000000;
    localparam longint DMAX_L  = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint DMIN_L  = -DMAX_L - 1;
    localparam longint IHI_L   = (LINT_L < DMAX_L) ? LINT_L : DMAX_L;
    localparam longint ILO_L   = (-LINT_L > DMIN_L) ? -LINT_L : DMIN_L;
    localparam int     YEW     = ((FB + 4 > 21) ? FB + 4 : 21) + 1;
    localparam int     WW      = ((DW > YEW) ? DW : YEW) + 6;

    localparam logic [KW-1:0] K_KP  = KW'(KP_L);
    localparam logic [KW-1:0] K_KD  = KW'(KD_L);
    localparam logic [KW-1:0] K_KDY = KW'(KDY_L);
    localparam logic [KW-1:0] K_KI  = KW'(KI_L);

    localparam logic signed [YEW-1:0] PIH_Y = YEW'(PIH_L);
    localparam logic signed [YEW-1:0] TPI_Y = YEW'(TPI_L);
    localparam logic signed [WW-1:0]  ONE_W = WW'(ONE_Q);
    localparam logic signed [WW-1:0]  LFZ_W = WW'(LFZ_L);
    localparam logic signed [WW-1:0]  LFX_W = WW'(LFX_L);
    localparam logic signed [WW-1:0]  IHI_W = WW'(IHI_L);
    localparam logic signed [WW-1:0]  ILO_W = WW'(ILO_L);
    localparam logic signed [WW-1:0]  DMAX_W = WW'(DMAX_L);
    localparam logic signed [WW-1:0]  DMIN_W = WW'(DMIN_L);

    typedef struct packed {
        logic [DW-1:0]  ex;
        logic [DW-1:0]  ez;
        logic [YEW-1:0] ey;
        logic [DW+3:0]  pex;
        logic [DW+3:0]  pez;
    } carry_t;

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [WW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > DMAX_W)
            r = DW'(DMAX_W);
        else if (v < DMIN_W)
            r = DW'(DMIN_W);
        else
            r = DW'(v);
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp_one(input logic signed [WW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > ONE_W)
            r = CW'(ONE_W);
        else if (v < -ONE_W)
            r = CW'(-ONE_W);
        else
            r = CW'(v);
        return r;
    endfunction

    // State
    logic signed [DW-1:0]    target_x_reg, target_z_reg;
    logic signed [YAW_W-1:0] target_yaw_reg;
    logic signed [DW-1:0]    last_err_x_reg, last_err_z_reg;
    logic signed [YEW-1:0]   last_err_yaw_reg;
    logic signed [DW-1:0]    integ_z_reg, last_force_x_reg, last_force_z_reg;

    // Pipeline payload
    logic signed [DW-1:0]  ex1_reg, ez1_reg;
    logic signed [YEW-1:0] ey1_reg;
    carry_t                c2_reg, c3_reg, c4_reg, c5_reg;
    logic signed [DW-1:0]  force_x_reg, force_z_reg, torque_yaw_reg;

    logic signed [DW:0]    dx_raw, dz_raw;
    logic signed [YEW-1:0] dy_raw, ey_wrap;
    logic signed [DW-1:0]  ex1_next, ez1_next;
    logic signed [YEW-1:0] ey1_next;
    carry_t                c2_next;
    logic signed [DW+3:0]  kp_x_p, kp_z_p;

    logic signed [DW-1:0]  q5;
    logic signed [CW-1:0]  dxc, dzc, dyc;
    logic signed [CW+3:0]  kd_x_p, kd_z_p, kd_y_p;
    logic signed [DW-1:0]  integ_base, integ_z_next;
    logic signed [WW-1:0]  isum, iclamp;
    logic                  grow;
    logic signed [DW+3:0]  ki_p;
    logic signed [WW-1:0]  fx_sum, fz_sum, ty_sum;
    logic signed [DW-1:0]  fx_next, fz_next, ty_next;

    // Error stage: in hold mode the target takes the measurement, so errors are zero
    assign dx_raw = {meas_x[DW-1], meas_x} - {target_x_reg[DW-1], target_x_reg};
    assign dz_raw = {meas_z[DW-1], meas_z} - {target_z_reg[DW-1], target_z_reg};
    assign dy_raw = YEW'(meas_yaw) - YEW'(target_yaw_reg);

    always_comb
    begin
        if (dy_raw > PIH_Y)
            ey_wrap = dy_raw - TPI_Y;
        else if (dy_raw < -PIH_Y)
            ey_wrap = dy_raw + TPI_Y;
        else
            ey_wrap = dy_raw;
    end

    assign ex1_next = cfg.hold_mode ? '0 : sat_dw(WW'(dx_raw));
    assign ez1_next = cfg.hold_mode ? '0 : sat_dw(WW'(dz_raw));
    assign ey1_next = cfg.hold_mode ? '0 : ey_wrap;

    // Proportional products
    ppd_mulk #(.AW(DW), .FB(FB), .KV(K_KP)) u_kp_x (.a(ex1_reg), .p(kp_x_p));
    ppd_mulk #(.AW(DW), .FB(FB), .KV(K_KP)) u_kp_z (.a(ez1_reg), .p(kp_z_p));

    always_comb
    begin
        c2_next.ex  = ex1_reg;
        c2_next.ez  = ez1_reg;
        c2_next.ey  = ey1_reg;
        c2_next.pex = kp_x_p;
        c2_next.pez = kp_z_p;
    end

    ppd_div10 #(.DW(DW)) u_div10 (
        .clk      (clk),
        .ld       (ld),
        .dividend (ez1_reg),
        .quotient (q5)
    );

    // Final stage: difference terms and integral against the previous word
    assign dxc = clamp_one(WW'($signed(c5_reg.ex)) - WW'(last_err_x_reg));
    assign dzc = clamp_one(WW'($signed(c5_reg.ez)) - WW'(last_err_z_reg));
    assign dyc = clamp_one(WW'($signed(c5_reg.ey)) - WW'(last_err_yaw_reg));

    ppd_mulk #(.AW(CW), .FB(FB), .KV(K_KD))  u_kd_x (.a(dxc), .p(kd_x_p));
    ppd_mulk #(.AW(CW), .FB(FB), .KV(K_KD))  u_kd_z (.a(dzc), .p(kd_z_p));
    ppd_mulk #(.AW(CW), .FB(FB), .KV(K_KDY)) u_kd_y (.a(dyc), .p(kd_y_p));

    assign integ_base = (cfg.max_thrust_pct < THRUST_INT_MIN) ? '0 : integ_z_reg;
    assign grow = (WW'(last_force_z_reg) < LFZ_W) && (WW'(last_force_z_reg) > -LFZ_W)
               && (WW'(last_force_x_reg) < LFX_W) && (WW'(last_force_x_reg) > -LFX_W)
               && !cfg.hold_mode;
    assign isum = WW'(integ_base) + WW'(q5);

    always_comb
    begin
        if (isum > IHI_W)
            iclamp = IHI_W;
        else if (isum < ILO_W)
            iclamp = ILO_W;
        else
            iclamp = isum;
    end

    assign integ_z_next = grow ? DW'(iclamp) : integ_base;

    ppd_mulk #(.AW(DW), .FB(FB), .KV(K_KI)) u_ki (.a(integ_z_next), .p(ki_p));

    assign fx_sum = -(WW'($signed(c5_reg.pex)) + WW'(kd_x_p));
    assign fz_sum = -(WW'($signed(c5_reg.pez)) + WW'(kd_z_p)) + WW'(ki_p);
    assign ty_sum = -((WW'($signed(c5_reg.ey)) <<< 1) + WW'(kd_y_p));

    assign fx_next = sat_dw(fx_sum);
    assign fz_next = sat_dw(fz_sum);
    assign ty_next = sat_dw(ty_sum);

    assign force_x    = force_x_reg;
    assign force_z    = force_z_reg;
    assign torque_yaw = torque_yaw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg     <= '0;
            target_z_reg     <= '0;
            target_yaw_reg   <= '0;
            last_err_x_reg   <= '0;
            last_err_z_reg   <= '0;
            last_err_yaw_reg <= '0;
            integ_z_reg      <= '0;
            last_force_x_reg <= '0;
            last_force_z_reg <= '0;
        end
        else
        begin
            if (ld.ld_s1 && cfg.hold_mode)
            begin
                target_x_reg   <= meas_x;
                target_z_reg   <= meas_z;
                target_yaw_reg <= meas_yaw;
            end
            if (ld.ld_out)
            begin
                if (cfg.enable)
                begin
                    last_err_x_reg   <= $signed(c5_reg.ex);
                    last_err_z_reg   <= $signed(c5_reg.ez);
                    last_err_yaw_reg <= $signed(c5_reg.ey);
                    integ_z_reg      <= integ_z_next;
                    last_force_x_reg <= fx_next;
                    last_force_z_reg <= fz_next;
                end
                else
                begin
                    // Disabled word: drop the integral, keep everything else
                    integ_z_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld_s1)
        begin
            ex1_reg <= ex1_next;
            ez1_reg <= ez1_next;
            ey1_reg <= ey1_next;
        end
        if (ld.ld_s2)
            c2_reg <= c2_next;
        if (ld.ld_s3)
            c3_reg <= c2_reg;
        if (ld.ld_s4)
            c4_reg <= c3_reg;
        if (ld.ld_s5)
            c5_reg <= c4_reg;
        if (ld.ld_out && cfg.enable)
        begin
            force_x_reg    <= fx_next;
            force_z_reg    <= fz_next;
            torque_yaw_reg <= ty_next;
        end
    end

endmodule

// ===== sv/pose_pd_controller_with_z_integral_core.sv =====
// Top level of the pose PD controller with conditional z integral.
// Depends on ppd_pkg, ppd_cfg and ppd_datapath.
//
// Takes one measurement word (x, z, yaw in signed fixed point) per clock while
// in_ready is high. For every enabled input it presents one force/torque word on
// the output once it has passed the pipeline stages and the output register. A
// word taken while the controller is disabled clears the z integral and produces
// no output. Throughput is one word per clock while the output is not stalled,
// set by the final stage, where the last errors, last forces and the z integral
// are updated and fed back to the next word. The stages before it form the errors,
// the proportional products and the divide by ten of the z error. The input is
// refused only when every stage and the output register are full and the output
// word is not being taken. Configuration must be written while the block is empty.
module pose_pd_controller_with_z_integral_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [DATA_WIDTH-1:0]       meas_x,
    input  logic signed [DATA_WIDTH-1:0]       meas_z,
    input  logic signed [ppd_pkg::YAW_W-1:0]   meas_yaw,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [DATA_WIDTH-1:0]       force_x,
    output logic signed [DATA_WIDTH-1:0]       force_z,
    output logic signed [DATA_WIDTH-1:0]       torque_yaw,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ppd_pkg::CFG_AW-1:0]         paddr,
    input  logic [ppd_pkg::CFG_DW-1:0]         pwdata,
    output logic [ppd_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready
);
    import ppd_pkg::*;

    cfg_t     cfg;
    pipe_ld_t ld;

    logic [PIPE_STAGES:1] v_reg, v_next;
    logic [PIPE_STAGES:0] mv;
    logic [PIPE_STAGES:1] free;
    logic                 out_valid_reg, out_valid_next;
    logic                 in_acc;

    // Last stage drains a disabled word without needing the output register
    always_comb
    begin
        mv[PIPE_STAGES]   = v_reg[PIPE_STAGES]
                         && (!cfg.enable || !out_valid_reg || out_ready);
        free[PIPE_STAGES] = !v_reg[PIPE_STAGES] || mv[PIPE_STAGES];
        for (int k = PIPE_STAGES - 1; k >= 1; k--)
        begin
            mv[k]   = v_reg[k] && free[k+1];
            free[k] = !v_reg[k] || mv[k];
        end
        mv[0] = in_acc;
    end

    assign in_ready = free[1];
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        for (int k = 1; k <= PIPE_STAGES; k++)
            v_next[k] = (v_reg[k] && !mv[k]) || mv[k-1];
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (mv[PIPE_STAGES] && cfg.enable);
    assign out_valid      = out_valid_reg;

    always_comb
    begin
        ld.ld_s1  = mv[0];
        ld.ld_s2  = mv[1];
        ld.ld_s3  = mv[2];
        ld.ld_s4  = mv[3];
        ld.ld_s5  = mv[4];
        ld.ld_out = mv[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg         <= v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    ppd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppd_datapath #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ld         (ld),
        .cfg        (cfg),
        .meas_x     (meas_x),
        .meas_z     (meas_z),
        .meas_yaw   (meas_yaw),
        .force_x    (force_x),
        .force_z    (force_z),
        .torque_yaw (torque_yaw)
    );

endmodule

// ===== sv/ppd_checker.sv =====
// Port-level checks for the pose PD controller core, bound to the top level.
// Depends on ppd_pkg and pose_pd_controller_with_z_integral_core.
module ppd_checker #(
    parameter int DW = 32
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [DW-1:0]               force_x,
    input logic [DW-1:0]               force_z,
    input logic [DW-1:0]               torque_yaw,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [ppd_pkg::CFG_AW-1:0]  paddr,
    input logic [ppd_pkg::CFG_DW-1:0]  pwdata,
    input logic [ppd_pkg::CFG_DW-1:0]  prdata,
    input logic                        pready
);
    import ppd_pkg::*;

    logic     en_shadow_reg;
    logic     seen_en_reg;
    logic     cfg_wr;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_shadow_reg <= 1'b0;
            seen_en_reg   <= 1'b0;
        end
        else if (cfg_wr && idx == REG_ENABLE)
        begin
            en_shadow_reg <= pwdata[0];
            seen_en_reg   <= seen_en_reg || pwdata[0];
        end
    end

    // Output word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_x)
                                    && $stable(force_z) && $stable(torque_yaw))
        else $error("output word changed while stalled");

    // A free or draining output register frees the whole pipeline
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input refused although output side is free");

    // No result before the controller was ever enabled
    a_no_result_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_en_reg |-> !out_valid)
        else $error("result produced while never enabled");

    // Enable register reads back what was written
    a_enable_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && idx == REG_ENABLE |-> prdata == CFG_DW'(en_shadow_reg))
        else $error("enable readback mismatch");

endmodule

bind pose_pd_controller_with_z_integral_core ppd_checker #(.DW(DATA_WIDTH)) u_ppd_checker (.*);
